FILE: hw/rtl/hsv_to_rgb888_top_macros.svh
// Assertion macros shared by the HSV to RGB888 checker file
`ifndef HSV_TO_RGB888_TOP_MACROS_SVH
`define HSV_TO_RGB888_TOP_MACROS_SVH

// same-cycle implication, off while reset is low
`define HSV_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("hsv2rgb check failed");

// next-cycle implication, off while reset is low
`define HSV_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("hsv2rgb check failed");

`endif

FILE: hw/rtl/hsv2rgb_pkg.sv
// Package: widths, word types and sector codes for the HSV to RGB888 converter
package hsv2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int INT_BITS  = 4;
    localparam int IN_W      = INT_BITS + FRAC_BITS;
    localparam int THR_W     = 13;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int W_W       = VAL_W + CH_W - 1;
    localparam int FAC_W     = 2 * FRAC_BITS + 1;
    localparam int H6_W      = FRAC_BITS + 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(13);
    localparam logic [CH_W-1:0]  CH_MAX    = {CH_W{1'b1}};
    localparam logic [VAL_W-1:0] ONE_FX    = VAL_W'(1) << FRAC_BITS;
    localparam logic [FAC_W-1:0] FULL_FX   = FAC_W'(1) << (2 * FRAC_BITS);

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] saturation;
        logic [IN_W-1:0] brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [RGB_W-1:0] rgb_word;
        logic             grey_taken;
    } t_rgb_word;

    // classified word, front to back
    typedef struct packed {
        logic                 grey;
        logic [CH_W-1:0]      grey_val;
        t_sector              sector;
        logic [FRAC_BITS-1:0] frac;
        logic [VAL_W-1:0]     sat;
        logic [VAL_W-1:0]     val;
    } t_cls;

endpackage

FILE: hw/rtl/hsv2rgb_front.sv
// Front end: grey test, range reduction, sector and fraction of hue
module hsv2rgb_front (
    input  hsv2rgb_pkg::t_hsv_word               i_word,
    input  logic [hsv2rgb_pkg::THR_W-1:0]        i_thr,
    output hsv2rgb_pkg::t_cls                    o_cls
);

    localparam int GP_W = hsv2rgb_pkg::IN_W + hsv2rgb_pkg::CH_W;
    localparam int GS_W = GP_W - hsv2rgb_pkg::FRAC_BITS;

    function automatic logic [hsv2rgb_pkg::VAL_W-1:0] fx_reduce(
        input logic [hsv2rgb_pkg::IN_W-1:0] x
    );
        logic [hsv2rgb_pkg::VAL_W-1:0] r;
        if (x > hsv2rgb_pkg::IN_W'(hsv2rgb_pkg::ONE_FX)) begin
            r = {1'b0, x[hsv2rgb_pkg::FRAC_BITS-1:0]};
        end else begin
            r = x[hsv2rgb_pkg::VAL_W-1:0];
        end
        return r;
    endfunction

    logic [GP_W-1:0]                     gp;
    logic [GS_W-1:0]                     gs;
    logic [hsv2rgb_pkg::FRAC_BITS-1:0]   h12;
    logic [hsv2rgb_pkg::H6_W-1:0]        h6;

    // v*255 as v*256 - v
    assign gp = {i_word.brightness, hsv2rgb_pkg::CH_W'(0)} - GP_W'(i_word.brightness);
    assign gs = gp[GP_W-1:hsv2rgb_pkg::FRAC_BITS];
    assign h12 = i_word.hue[hsv2rgb_pkg::FRAC_BITS-1:0];
    assign h6 = (hsv2rgb_pkg::H6_W'(h12) << 2) + (hsv2rgb_pkg::H6_W'(h12) << 1);

    always_comb begin
        o_cls.grey     = i_word.saturation < hsv2rgb_pkg::IN_W'(i_thr);
        o_cls.grey_val = (|gs[GS_W-1:hsv2rgb_pkg::CH_W]) ? hsv2rgb_pkg::CH_MAX
                                                          : gs[hsv2rgb_pkg::CH_W-1:0];
        o_cls.sector   = hsv2rgb_pkg::t_sector'(h6[hsv2rgb_pkg::H6_W-1:hsv2rgb_pkg::FRAC_BITS]);
        o_cls.frac     = h6[hsv2rgb_pkg::FRAC_BITS-1:0];
        o_cls.sat      = fx_reduce(i_word.saturation);
        o_cls.val      = fx_reduce(i_word.brightness);
    end

endmodule

FILE: hw/rtl/hsv2rgb_queue.sv
// Short word queue between front and back
module hsv2rgb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hsv2rgb_pkg::t_cls i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hsv2rgb_pkg::t_cls o_data
);

    hsv2rgb_pkg::t_cls                  r_mem [hsv2rgb_pkg::Q_DEPTH];
    logic [hsv2rgb_pkg::Q_PTR_W-1:0]    r_wptr, n_wptr;
    logic [hsv2rgb_pkg::Q_PTR_W-1:0]    r_rptr, n_rptr;
    logic [hsv2rgb_pkg::Q_CNT_W-1:0]    r_cnt, n_cnt;
    logic                               push, pop;

    localparam logic [hsv2rgb_pkg::Q_PTR_W-1:0] LAST =
        hsv2rgb_pkg::Q_PTR_W'(hsv2rgb_pkg::Q_DEPTH - 1);

    assign o_ready = r_cnt != hsv2rgb_pkg::Q_CNT_W'(hsv2rgb_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/hsv2rgb_back.sv
// Back end: weight products, channel products and sector select
module hsv2rgb_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  hsv2rgb_pkg::t_cls      i_cls,
    output logic                   o_valid,
    input  logic                   i_ready,
    output hsv2rgb_pkg::t_rgb_word o_word
);

    localparam int F   = hsv2rgb_pkg::FRAC_BITS;
    localparam int CW  = hsv2rgb_pkg::CH_W;
    localparam int WW  = hsv2rgb_pkg::W_W;
    localparam int VW  = hsv2rgb_pkg::VAL_W;
    localparam int FW  = hsv2rgb_pkg::FAC_W;
    localparam int SF_W = VW + F;
    localparam int ST_W = 2 * VW;
    localparam int PP_W = WW + VW;
    localparam int QP_W = WW + FW;

    typedef struct packed {
        logic                 grey;
        logic [CW-1:0]        grey_val;
        hsv2rgb_pkg::t_sector sector;
        logic [WW-1:0]        w;
        logic [VW-1:0]        ps;
        logic [FW-1:0]        fq;
        logic [FW-1:0]        ft;
    } t_fac;

    logic                   r_a_valid, n_a_valid;
    t_fac                   r_a, n_a;
    logic                   r_o_valid, n_o_valid;
    hsv2rgb_pkg::t_rgb_word r_o_word, n_o_word;

    logic                   b_load, a_load;
    logic [SF_W-1:0]        sf;
    logic [ST_W-1:0]        st;
    logic [VW+CW-1:0]       wfull;
    logic [PP_W-1:0]        pp;
    logic [QP_W-1:0]        qp, tp;
    logic [CW-1:0]          cv, cp, cq, ct;

    assign b_load  = !r_o_valid || i_ready;
    assign a_load  = !r_a_valid || b_load;
    assign o_ready = a_load;
    assign o_valid = r_o_valid;
    assign o_word  = r_o_word;

    // stage A: s*f, s*(1-f), 255*v
    assign sf    = SF_W'(i_cls.sat) * SF_W'(i_cls.frac);
    assign st    = ST_W'(i_cls.sat) * ST_W'(hsv2rgb_pkg::ONE_FX - VW'(i_cls.frac));
    assign wfull = {i_cls.val, CW'(0)} - (VW + CW)'(i_cls.val);

    always_comb begin
        n_a_valid = r_a_valid;
        n_a       = r_a;
        if (a_load) begin
            n_a_valid   = i_valid;
            n_a.grey    = i_cls.grey;
            n_a.grey_val = i_cls.grey_val;
            n_a.sector  = i_cls.sector;
            n_a.w       = wfull[WW-1:0];
            n_a.ps      = hsv2rgb_pkg::ONE_FX - i_cls.sat;
            n_a.fq      = hsv2rgb_pkg::FULL_FX - sf[FW-1:0];
            n_a.ft      = hsv2rgb_pkg::FULL_FX - st[FW-1:0];
        end
    end

    // stage B: channel products, truncated toward zero
    assign pp = PP_W'(r_a.w) * PP_W'(r_a.ps);
    assign qp = QP_W'(r_a.w) * QP_W'(r_a.fq);
    assign tp = QP_W'(r_a.w) * QP_W'(r_a.ft);
    assign cv = r_a.w[F+CW-1:F];
    assign cp = pp[2*F+CW-1:2*F];
    assign cq = qp[3*F+CW-1:3*F];
    assign ct = tp[3*F+CW-1:3*F];

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_word  = r_o_word;
        if (b_load) begin
            n_o_valid           = r_a_valid;
            n_o_word.grey_taken = r_a.grey;
            if (r_a.grey) begin
                n_o_word.rgb_word = {r_a.grey_val, r_a.grey_val, r_a.grey_val};
            end else begin
                case (r_a.sector)
                    hsv2rgb_pkg::SEC_RY: begin
                        n_o_word.rgb_word = {cv, ct, cp};
                    end
                    hsv2rgb_pkg::SEC_YG: begin
                        n_o_word.rgb_word = {cq, cv, cp};
                    end
                    hsv2rgb_pkg::SEC_GC: begin
                        n_o_word.rgb_word = {cp, cv, ct};
                    end
                    hsv2rgb_pkg::SEC_CB: begin
                        n_o_word.rgb_word = {cp, cq, cv};
                    end
                    hsv2rgb_pkg::SEC_BM: begin
                        n_o_word.rgb_word = {ct, cp, cv};
                    end
                    default: begin
                        n_o_word.rgb_word = {cv, cp, cq};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_o_word <= n_o_word;
    end

endmodule

FILE: hw/rtl/hsv_to_rgb888_top.sv
// Top level of the HSV to RGB888 converter
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+--------------------------------
//   in      | i_in_valid  | o_in_ready  | i_in_word  (hue, sat, value)
//   out     | o_out_valid | i_out_ready | o_out_word (rgb_word, grey)
//   cfg     | i_cfg_we    | -           | i_cfg_wdata (mono threshold)
//
// One word per cycle sustained while the output is not stalled; a result passes
// through queue entry, weight stage and channel multiply stage, each registered.
// With the output stalled, the two stages and the two-entry queue hold four
// words; then the queue is full and o_in_ready drops.
// Reset empties queue and pipeline and sets the threshold to 13.
module hsv_to_rgb888_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hsv2rgb_pkg::t_hsv_word            i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hsv2rgb_pkg::t_rgb_word            o_out_word,
    input  logic                              i_cfg_we,
    input  logic [hsv2rgb_pkg::THR_W-1:0]     i_cfg_wdata
);

    logic [hsv2rgb_pkg::THR_W-1:0] r_mono_threshold;
    hsv2rgb_pkg::t_cls             front_cls;
    hsv2rgb_pkg::t_cls             q_cls;
    logic                          q_valid, back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono_threshold <= hsv2rgb_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_mono_threshold <= i_cfg_wdata;
        end
    end

    hsv2rgb_front u_front (
        .i_word (i_in_word),
        .i_thr  (r_mono_threshold),
        .o_cls  (front_cls)
    );

    hsv2rgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (front_cls),
        .o_valid (q_valid),
        .i_ready (back_ready),
        .o_data  (q_cls)
    );

    hsv2rgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (back_ready),
        .i_cls   (q_cls),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

FILE: hw/rtl/hsv2rgb_checker.sv
// Port checker for the HSV to RGB888 converter, bound to the top level
`include "hsv_to_rgb888_top_macros.svh"

module hsv2rgb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_ready,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  hsv2rgb_pkg::t_rgb_word            o_out_word
);

    logic grey_match;

    assign grey_match = (o_out_word.rgb_word[23:16] == o_out_word.rgb_word[15:8]) &&
                        (o_out_word.rgb_word[15:8] == o_out_word.rgb_word[7:0]);

    `HSV_ASSERT_IMP(a_empty_after_reset, $rose(i_rst_n), !o_out_valid)

    `HSV_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))

    `HSV_ASSERT_IMP(a_grey_equal, o_out_valid && o_out_word.grey_taken, grey_match)

    // input can only back up behind a held output word
    `HSV_ASSERT_IMP(a_stall_source, !o_in_ready, o_out_valid)

endmodule

bind hsv_to_rgb888_top hsv2rgb_checker u_hsv2rgb_checker (.*);

FILE: sim/testbench.sv
// HSV to RGB888 converter testbench: random and corner-case pixels checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import hsv2rgb_pkg::*;

    localparam logic [63:0] UNIT       = 64'd1 << FRAC_BITS;
    localparam logic [63:0] FMASK      = UNIT - 64'd1;
    localparam int          STALL_MAX  = 15;
    localparam int          HOLD_LEN   = 300;
    localparam int          IDLE_LIMIT = 5000;
    localparam int          PHASES     = 6;
    localparam int          PHASE_LEN  = 305;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_hsv_word            i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_rgb_word            o_out_word;
    logic                 i_cfg_we = 1'b0;
    logic [THR_W-1:0]     i_cfg_wdata = '0;

    class color_scoreboard;
        logic [THR_W-1:0] threshold;
        t_rgb_word        rgb_due[$];
        int               errors;

        function new();
            threshold = THR_RESET;
            errors    = 0;
        endfunction

        function logic [63:0] channel_level(logic [63:0] v, logic [63:0] fac);
            logic [63:0] lvl;
            lvl = (64'd255 * v * fac) >> (3 * FRAC_BITS);
            return (lvl > 64'd255) ? 64'd255 : lvl;
        endfunction

        function t_rgb_word hsv_convert(t_hsv_word w);
            logic [63:0] h, s, v, h6, f, grey, cv, cp, cq, ct, r, g, b;
            t_sector     sector;
            t_rgb_word   res;
            h = 64'(w.hue);
            s = 64'(w.saturation);
            v = 64'(w.brightness);
            if (w.saturation < 16'(threshold)) begin
                grey = (v * 64'd255) >> FRAC_BITS;
                if (grey > 64'd255)
                    grey = 64'd255;
                res.rgb_word   = {grey[7:0], grey[7:0], grey[7:0]};
                res.grey_taken = 1'b1;
                return res;
            end
            if (h >= UNIT)
                h &= FMASK;
            if (s > UNIT)
                s &= FMASK;
            if (v > UNIT)
                v &= FMASK;
            h6     = h * 64'd6;
            sector = t_sector'(h6[FRAC_BITS+2:FRAC_BITS]);
            f      = h6 & FMASK;
            cv = channel_level(v, UNIT * UNIT);
            cp = channel_level(v, (UNIT - s) * UNIT);
            cq = channel_level(v, UNIT * UNIT - s * f);
            ct = channel_level(v, UNIT * UNIT - s * (UNIT - f));
            case (sector)
                SEC_RY: begin r = cv; g = ct; b = cp; end
                SEC_YG: begin r = cq; g = cv; b = cp; end
                SEC_GC: begin r = cp; g = cv; b = ct; end
                SEC_CB: begin r = cp; g = cq; b = cv; end
                SEC_BM: begin r = ct; g = cp; b = cv; end
                default: begin r = cv; g = cp; b = cq; end
            endcase
            res.rgb_word   = {r[7:0], g[7:0], b[7:0]};
            res.grey_taken = 1'b0;
            return res;
        endfunction

        function void note_pixel(t_hsv_word w);
            rgb_due.push_back(hsv_convert(w));
        endfunction

        function void check_pixel(t_rgb_word got);
            t_rgb_word want;
            if (rgb_due.size() == 0) begin
                $error("unexpected output word %07h", got);
                errors++;
                return;
            end
            want = rgb_due.pop_front();
            if (got.rgb_word !== want.rgb_word) begin
                $error("rgb_word: expected %06h, actual %06h", want.rgb_word, got.rgb_word);
                errors++;
            end
            if (got.grey_taken !== want.grey_taken) begin
                $error("grey_taken: expected %0b, actual %0b", want.grey_taken,
                       got.grey_taken);
                errors++;
            end
        endfunction
    endclass

    color_scoreboard sb = new();
    int              in_mode = 0;
    int              out_mode = 0;
    int              hold_req = 0;
    int              idle_cycles = 0;

    hsv_to_rgb888_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_pixel(i_in_word);
            if (o_out_valid && i_out_ready)
                sb.check_pixel(o_out_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int draw_gap(int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, STALL_MAX) : 0;
            default: return $urandom_range(0, STALL_MAX);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pick_field();
        case ($urandom_range(0, 6))
            0, 1: return IN_W'($urandom_range(0, 4096));
            2: return IN_W'($urandom_range(4095, 4097));
            3: return IN_W'($urandom_range(0, 15));
            4: return IN_W'($urandom_range(65520, 65535));
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic t_hsv_word random_pixel();
        t_hsv_word w;
        int        t;
        w.hue        = pick_field();
        w.saturation = pick_field();
        w.brightness = pick_field();
        if ($urandom_range(0, 5) == 0) begin
            t = int'(sb.threshold) + $urandom_range(0, 4) - 2;
            w.saturation = IN_W'((t < 0) ? 0 : t);
        end
        return w;
    endfunction

    function automatic t_hsv_word pixel(int h, int s, int v);
        t_hsv_word w;
        w.hue        = IN_W'(h);
        w.saturation = IN_W'(s);
        w.brightness = IN_W'(v);
        return w;
    endfunction

    task automatic send_pixel(input t_hsv_word w, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (sb.rgb_due.size() != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        i_in_valid <= 1'b0;
        drain_results();
        repeat (6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.threshold = thr;
    endtask

    // output side: random back-pressure plus an occasional long hold-off
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = draw_gap(out_mode);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [THR_W-1:0] thr;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners at the reset threshold: sector edges, grey edge, reductions
        send_pixel(pixel(0, 4096, 4096), 0);
        send_pixel(pixel(683, 4096, 4096), 0);
        send_pixel(pixel(1366, 4096, 4096), 0);
        send_pixel(pixel(2048, 4096, 4096), 0);
        send_pixel(pixel(2731, 4096, 4096), 0);
        send_pixel(pixel(3414, 4096, 4096), 0);
        send_pixel(pixel(4095, 4096, 4096), 0);
        send_pixel(pixel(4096, 2048, 3000), 0);
        send_pixel(pixel(65535, 65535, 65535), 0);
        send_pixel(pixel(1000, 0, 0), 0);
        send_pixel(pixel(1000, 0, 4096), 0);
        send_pixel(pixel(1000, 0, 65535), 0);
        send_pixel(pixel(1000, 12, 2000), 0);
        send_pixel(pixel(1000, 13, 2000), 0);
        send_pixel(pixel(1500, 8192, 4096), 0);
        send_pixel(pixel(1500, 4097, 4097), 0);
        send_pixel(pixel(2500, 4095, 4095), 0);
        send_pixel(pixel(3000, 2048, 0), 0);
        send_pixel(pixel(8000, 3000, 1234), 0);
        send_pixel(pixel(682, 4096, 4096), 0);
        send_pixel(pixel(3413, 1, 4096), 0);
        send_pixel(pixel(0, 0, 1), 0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: thr = THR_RESET;
                1: thr = '0;
                2: thr = THR_W'(4096);
                3: thr = '1;
                4: thr = THR_W'($urandom_range(1, 4095));
                default: thr = THR_W'($urandom_range(0, 4096));
            endcase
            write_threshold(thr);
            in_mode  = p % 3;
            out_mode = (p + 1) % 3;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (p == 2 && n == 50)
                    hold_req = HOLD_LEN;
                if (p == 4 && n == 150) begin
                    i_in_valid <= 1'b0;
                    drain_results();
                end
                send_pixel(random_pixel(), (p == 2 && n < 120) ? 0 : draw_gap(in_mode));
            end
        end
        i_in_valid <= 1'b0;

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.rgb_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_front.sv
hw/rtl/hsv2rgb_queue.sv
hw/rtl/hsv2rgb_back.sv
hw/rtl/hsv_to_rgb888_top.sv
hw/rtl/hsv2rgb_checker.sv
sim/testbench.sv
